// File: hdl/dsfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types, status codes and the power-of-ten table for the decimal
// string to fixed-point converter.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam int MAX_SCALE = 18;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_LONE_SIGN   = 3'd2;
  localparam logic [2:0] ST_DIGIT_OVF   = 3'd3;
  localparam logic [2:0] ST_EXCESS_FRAC = 3'd4;
  localparam logic [2:0] ST_JUNK        = 3'd5;
  localparam logic [2:0] ST_NO_DIGITS   = 3'd6;
  localparam logic [2:0] ST_SCALE_OVF   = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_t;

  // Finished string, handed from the scanner to the scaling pipeline.
  typedef struct packed {
    logic [2:0]  status;
    logic        neg;
    logic [62:0] whole;
    logic [59:0] frac;
    logic [4:0]  frac_count;
    logic [4:0]  scale;
  } mid_t;

  function automatic logic [59:0] pow10(input logic [4:0] n);
    logic [59:0] r;
    case (n)
      5'd0:    r = 60'd1;
      5'd1:    r = 60'd10;
      5'd2:    r = 60'd100;
      5'd3:    r = 60'd1000;
      5'd4:    r = 60'd10000;
      5'd5:    r = 60'd100000;
      5'd6:    r = 60'd1000000;
      5'd7:    r = 60'd10000000;
      5'd8:    r = 60'd100000000;
      5'd9:    r = 60'd1000000000;
      5'd10:   r = 60'd10000000000;
      5'd11:   r = 60'd100000000000;
      5'd12:   r = 60'd1000000000000;
      5'd13:   r = 60'd10000000000000;
      5'd14:   r = 60'd100000000000000;
      5'd15:   r = 60'd1000000000000000;
      5'd16:   r = 60'd10000000000000000;
      5'd17:   r = 60'd100000000000000000;
      5'd18:   r = 60'd1000000000000000000;
      default: r = 60'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dsfp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfp_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module dsfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_wr && do_rd) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dsfp_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfp_scan
// Front end: classifies one character per cycle while item_valid_i is high,
// accumulates the integer and fraction digits, latches the first error and emits a finished string entry.
// ----------------------------------------------------------------------------
module dsfp_scan (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire dsfp_pkg::in_t  item_i,
  input  wire logic [4:0]     scale_i,
  output logic                done_o,
  output dsfp_pkg::mid_t      entry_o
);
  import dsfp_pkg::*;

  localparam logic [2:0] PH_LEAD       = 3'd0;
  localparam logic [2:0] PH_SIGN       = 3'd1;
  localparam logic [2:0] PH_WHOLE      = 3'd2;
  localparam logic [2:0] PH_FRAC       = 3'd3;
  localparam logic [2:0] PH_TRAIL      = 3'd4;
  localparam logic [2:0] PH_SIGN_TRAIL = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [62:0] WHOLE_LIMIT = 63'd922337203685477579;

  logic [2:0]  phase_q, phase_d, phase_n;
  logic        neg_q, neg_d, neg_n;
  logic        saw_digit_q, saw_digit_d, saw_digit_n;
  logic        saw_ns_q, saw_ns_d, saw_ns_n;
  logic [62:0] whole_q, whole_d, whole_n;
  logic [59:0] frac_q, frac_d, frac_n;
  logic [4:0]  fc_q, fc_d, fc_n;
  logic [2:0]  err_q, err_d, err_n;

  logic [7:0]  c;
  logic        ws, dig;
  logic [3:0]  d;
  logic [4:0]  s_eff;
  logic [62:0] whole_nx;
  logic [59:0] frac_nx;
  logic [4:0]  fc_inc;
  logic [2:0]  fin_st;

  assign c        = item_i.char_code;
  assign ws       = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign dig      = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d        = 4'(c - CH_ZERO);
  assign s_eff    = (scale_i > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : scale_i;
  assign whole_nx = {whole_q[59:0], 3'b000} + {whole_q[61:0], 1'b0} + {59'd0, d};
  assign frac_nx  = {frac_q[56:0], 3'b000} + {frac_q[58:0], 1'b0} + {56'd0, d};
  assign fc_inc   = (fc_q == 5'd31) ? fc_q : fc_q + 5'd1;

  always_comb begin
    phase_n     = phase_q;
    neg_n       = neg_q;
    saw_digit_n = saw_digit_q;
    saw_ns_n    = saw_ns_q;
    whole_n     = whole_q;
    frac_n      = frac_q;
    fc_n        = fc_q;
    err_n       = err_q;
    if (item_valid_i && item_i.has_char && (err_q == ST_OK)) begin
      if (!ws) begin
        saw_ns_n = 1'b1;
      end
      case (phase_q)
        PH_LEAD: begin
          if (!ws) begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              neg_n   = (c == CH_MINUS);
              phase_n = PH_SIGN;
            end else if (dig) begin
              whole_n     = whole_nx;
              saw_digit_n = 1'b1;
              phase_n     = PH_WHOLE;
            end else if (c == CH_DOT) begin
              phase_n = PH_FRAC;
            end else begin
              err_n = ST_JUNK;
            end
          end
        end
        PH_SIGN, PH_WHOLE: begin
          if (ws) begin
            phase_n = (phase_q == PH_SIGN) ? PH_SIGN_TRAIL : PH_TRAIL;
          end else if (dig) begin
            if (whole_q > WHOLE_LIMIT) begin
              err_n = ST_DIGIT_OVF;
            end else begin
              whole_n     = whole_nx;
              saw_digit_n = 1'b1;
              phase_n     = PH_WHOLE;
            end
          end else if (c == CH_DOT) begin
            phase_n = PH_FRAC;
          end else begin
            err_n = ST_JUNK;
          end
        end
        PH_FRAC: begin
          if (ws) begin
            phase_n = PH_TRAIL;
          end else if (dig) begin
            saw_digit_n = 1'b1;
            if (fc_q < s_eff) begin
              frac_n = frac_nx;
              fc_n   = fc_inc;
            end else if (d != 4'd0) begin
              err_n = ST_EXCESS_FRAC;
            end else begin
              fc_n = fc_inc;
            end
          end else begin
            err_n = ST_JUNK;
          end
        end
        default: begin
          if (!ws) begin
            err_n = ST_JUNK;
          end
        end
      endcase
    end
  end

  always_comb begin
    fin_st = err_n;
    if (err_n == ST_OK) begin
      if (!saw_ns_n) begin
        fin_st = ST_EMPTY;
      end else if ((phase_n == PH_SIGN) || (phase_n == PH_SIGN_TRAIL)) begin
        fin_st = ST_LONE_SIGN;
      end else if (!saw_digit_n) begin
        fin_st = ST_NO_DIGITS;
      end
    end
  end

  assign done_o             = item_valid_i && item_i.last;
  assign entry_o.status     = fin_st;
  assign entry_o.neg        = neg_n;
  assign entry_o.whole      = whole_n;
  assign entry_o.frac       = frac_n;
  assign entry_o.frac_count = fc_n;
  assign entry_o.scale      = s_eff;

  always_comb begin
    if (done_o) begin
      phase_d     = PH_LEAD;
      neg_d       = 1'b0;
      saw_digit_d = 1'b0;
      saw_ns_d    = 1'b0;
      whole_d     = '0;
      frac_d      = '0;
      fc_d        = '0;
      err_d       = ST_OK;
    end else begin
      phase_d     = phase_n;
      neg_d       = neg_n;
      saw_digit_d = saw_digit_n;
      saw_ns_d    = saw_ns_n;
      whole_d     = whole_n;
      frac_d      = frac_n;
      fc_d        = fc_n;
      err_d       = err_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      neg_q       <= 1'b0;
      saw_digit_q <= 1'b0;
      saw_ns_q    <= 1'b0;
      whole_q     <= '0;
      frac_q      <= '0;
      fc_q        <= '0;
      err_q       <= ST_OK;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      saw_digit_q <= saw_digit_d;
      saw_ns_q    <= saw_ns_d;
      whole_q     <= whole_d;
      frac_q      <= frac_d;
      fc_q        <= fc_d;
      err_q       <= err_d;
    end
  end

  a_digit_only_in_digit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (saw_digit_q && (phase_q == PH_LEAD || phase_q == PH_SIGN || phase_q == PH_SIGN_TRAIL))
      |-> (phase_q != PH_SIGN && phase_q != PH_SIGN_TRAIL))
    else $error("digit seen while still in sign phase");

endmodule
`default_nettype wire

// File: hdl/dsfp_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfp_scale
// Back end: pipelined scaling of a finished string by the power of ten,
// overflow check, sign application and credit control of the result queue.
// ----------------------------------------------------------------------------
module dsfp_scale #(
  parameter int OUT_DEPTH = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           entry_valid_i,
  input  wire dsfp_pkg::mid_t entry_i,
  output logic                issue_o,
  input  wire logic           res_taken_i,
  output logic                res_valid_o,
  output dsfp_pkg::out_t      res_o
);
  import dsfp_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;

  // stage A: table lookup
  logic        a_v_q;
  logic [2:0]  a_st_q;
  logic        a_neg_q;
  logic [62:0] a_w_q;
  logic [59:0] a_f_q, a_p_q, a_m_q;
  logic [59:0] a_m_d;

  // stage B: partial products
  logic        b_v_q;
  logic [2:0]  b_st_q;
  logic        b_neg_q;
  logic [63:0] b_pp00_q, b_fq00_q;
  logic [59:0] b_pp01_q, b_fq01_q, b_fq10_q;
  logic [62:0] b_pp10_q;
  logic [58:0] b_pp11_q;

  // stage C: first reduction
  logic        c_v_q;
  logic [2:0]  c_st_q;
  logic        c_neg_q;
  logic [63:0] c_pp00_q, c_mid_q;
  logic [58:0] c_pp11_q;
  logic [59:0] c_f_q;

  // stage D: full integer product
  logic         d_v_q;
  logic [2:0]   d_st_q;
  logic         d_neg_q;
  logic [122:0] d_wp_q;
  logic [59:0]  d_f_q;

  // stage E: add fraction, check range
  logic         e_v_q;
  logic [2:0]   e_st_q;
  logic         e_neg_q;
  logic [63:0]  e_sum_q;
  logic         e_ovf_q;
  logic [123:0] e_tot_d;

  assign issue_o = entry_valid_i && (cnt_q < CNT_W'(OUT_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (issue_o && !res_taken_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!issue_o && res_taken_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign a_m_d = (entry_i.frac_count < entry_i.scale)
               ? pow10(entry_i.scale - entry_i.frac_count) : 60'd1;
  assign e_tot_d = {1'b0, d_wp_q} + {64'd0, d_f_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      a_v_q <= issue_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_st_q   <= entry_i.status;
    a_neg_q  <= entry_i.neg;
    a_w_q    <= entry_i.whole;
    a_f_q    <= entry_i.frac;
    a_p_q    <= pow10(entry_i.scale);
    a_m_q    <= a_m_d;

    b_st_q   <= a_st_q;
    b_neg_q  <= a_neg_q;
    b_pp00_q <= 64'(a_w_q[31:0]) * 64'(a_p_q[31:0]);
    b_pp01_q <= 60'(a_w_q[31:0]) * 60'(a_p_q[59:32]);
    b_pp10_q <= 63'(a_w_q[62:32]) * 63'(a_p_q[31:0]);
    b_pp11_q <= 59'(a_w_q[62:32]) * 59'(a_p_q[59:32]);
    // the fraction product stays below ten to the eighteenth: no high term
    b_fq00_q <= 64'(a_f_q[31:0]) * 64'(a_m_q[31:0]);
    b_fq01_q <= 60'(a_f_q[31:0]) * 60'(a_m_q[59:32]);
    b_fq10_q <= 60'(a_f_q[59:32]) * 60'(a_m_q[31:0]);

    c_st_q   <= b_st_q;
    c_neg_q  <= b_neg_q;
    c_pp00_q <= b_pp00_q;
    c_pp11_q <= b_pp11_q;
    c_mid_q  <= {4'd0, b_pp01_q} + {1'b0, b_pp10_q};
    c_f_q    <= 60'(b_fq00_q + {b_fq01_q[31:0], 32'd0} + {b_fq10_q[31:0], 32'd0});

    d_st_q   <= c_st_q;
    d_neg_q  <= c_neg_q;
    d_f_q    <= c_f_q;
    d_wp_q   <= {c_pp11_q, 64'd0} + {27'd0, c_mid_q, 32'd0} + {59'd0, c_pp00_q};

    e_st_q   <= d_st_q;
    e_neg_q  <= d_neg_q;
    e_sum_q  <= e_tot_d[63:0];
    e_ovf_q  <= |e_tot_d[123:63];
  end

  always_comb begin
    res_o.status = e_st_q;
    res_o.value  = '0;
    if (e_st_q == ST_OK) begin
      if (e_ovf_q) begin
        res_o.status = ST_SCALE_OVF;
      end else begin
        res_o.value = e_neg_q ? -e_sum_q : e_sum_q;
      end
    end
  end

  assign res_valid_o = e_v_q;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_DEPTH))
    else $error("result credit count beyond queue depth");

  a_sign_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK && res_o.value != 64'sd0)
      |-> (res_o.value[63] == e_neg_q))
    else $error("result sign does not match parsed sign");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |-> (res_o.value == 64'sd0))
    else $error("nonzero value on error result");

endmodule
`default_nettype wire

// File: hdl/decimal_string_to_fixed_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point
// ASCII decimal string to signed fixed-point integer scaled by a power of ten.
//
//   channel   handshake             payload
//   input     push / full           in_i   (char_code, has_char, last)
//   result    empty / pop           out_o  (value, status)
//   config    cfg_we_i              cfg_wdata_i (scale_digits)
//
// One character is taken every cycle while full is low. A finished string goes
// through the queue of finished strings, stages A to E and the result queue;
// the scaling pipeline takes one per cycle while the result queue has credit.
// Reset clears the string state and sets the scale to six.
// full rises only while the queue of finished strings is full; a stalled
// result side fills the result queue and then that queue.
// ----------------------------------------------------------------------------
module decimal_string_to_fixed_point #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire dsfp_pkg::in_t in_i,
  output logic               empty,
  input  wire logic          pop,
  output dsfp_pkg::out_t     out_o,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_wdata_i
);
  import dsfp_pkg::*;

  logic [4:0] scale_q;
  logic       in_fire;
  logic       done;
  mid_t       entry_wr, entry_rd;
  logic       mid_full, mid_empty;
  logic       issue;
  logic       res_valid;
  out_t       res;
  logic       out_full, out_empty;
  logic [$bits(out_t)-1:0] out_rdata;
  logic [$bits(mid_t)-1:0] mid_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 5'd6;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign full    = mid_full;
  assign in_fire = push && !mid_full;

  dsfp_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_fire),
    .item_i       (in_i),
    .scale_i      (scale_q),
    .done_o       (done),
    .entry_o      (entry_wr)
  );

  dsfp_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (done),
    .wr_data_i (entry_wr),
    .rd_en_i   (issue),
    .rd_data_o (mid_rdata),
    .full_o    (mid_full),
    .empty_o   (mid_empty)
  );

  assign entry_rd = mid_t'(mid_rdata);

  dsfp_scale #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (!mid_empty),
    .entry_i       (entry_rd),
    .issue_o       (issue),
    .res_taken_i   (pop && !out_empty),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  dsfp_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (pop),
    .rd_data_o (out_rdata),
    .full_o    (out_full),
    .empty_o   (out_empty)
  );

  assign empty = out_empty;
  assign out_o = out_t'(out_rdata);

  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result written into full result queue");

  a_no_string_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !mid_full)
    else $error("finished string written into full queue");

endmodule
`default_nettype wire
